@@ rtl/gradient_noise_2d_assert.svh @@
// assertion macros for the gradient noise block and its checker
`ifndef GRADIENT_NOISE_2D_ASSERT_SVH
`define GRADIENT_NOISE_2D_ASSERT_SVH

// same-cycle implication, checked outside reset
`define GN2D_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define GN2D_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/gn2d_pkg.sv @@
// constants, types and arithmetic helpers for the gradient noise block
`timescale 1ns / 1ps
`default_nettype none

package gn2d_pkg;

    localparam int TABLE_SIZE = 256;
    localparam int IDX_W      = $clog2(TABLE_SIZE);
    localparam int FRAC_BITS  = 16;
    localparam int COORD_W    = 32;
    localparam int Q_BITS     = 16;
    localparam int FRAC_ALIGN = Q_BITS + 8;
    localparam int ONE_Q16    = 1 << Q_BITS;

    localparam int FADE_C6    = 6;
    localparam int FADE_C15   = 15;
    localparam int FADE_C10   = 10;
    localparam int INNER_W    = Q_BITS + 4;
    localparam int INNER_EXT  = INNER_W + 1;
    localparam int FADE_W     = Q_BITS + 1;

    localparam int GRAD_W     = Q_BITS + 3;
    localparam int VAL_W      = Q_BITS + 4;
    localparam int OUT_W      = 16;
    localparam int OUT_SHIFT  = 2;
    localparam int SAT_MAX    = 32767;
    localparam int SAT_MIN    = -32768;

    // stages from acceptance to the output register
    localparam int PIPE_DEPTH = 7;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    typedef enum logic [1:0] {
        COEF_ZERO = 2'd0,
        COEF_POS  = 2'd1,
        COEF_NEG  = 2'd2
    } coef_t;

    // gradient selection by the low four hash bits, as x and y coefficients
    localparam coef_t GRAD_X_TBL [0:15] = '{
        COEF_POS,  COEF_NEG,  COEF_POS,  COEF_NEG,
        COEF_ZERO, COEF_ZERO, COEF_POS,  COEF_NEG,
        COEF_NEG,  COEF_ZERO, COEF_POS,  COEF_POS,
        COEF_NEG,  COEF_ZERO, COEF_POS,  COEF_NEG
    };
    localparam coef_t GRAD_Y_TBL [0:15] = '{
        COEF_POS,  COEF_POS,  COEF_NEG,  COEF_NEG,
        COEF_POS,  COEF_NEG,  COEF_ZERO, COEF_ZERO,
        COEF_NEG,  COEF_POS,  COEF_NEG,  COEF_POS,
        COEF_POS,  COEF_NEG,  COEF_ZERO, COEF_ZERO
    };

    // fraction bits of a coordinate brought to unsigned q0.16
    function automatic logic [Q_BITS-1:0] frac_q16(input logic [COORD_W-1:0] raw);
        logic [COORD_W-1:0] f;
        f = raw & COORD_W'((64'd1 << FRAC_BITS) - 64'd1);
        f = (f << (FRAC_ALIGN - FRAC_BITS)) >> (FRAC_ALIGN - Q_BITS);
        return f[Q_BITS-1:0];
    endfunction

    // 6*t2 - 15*t + 10, always positive over the q16 range
    function automatic logic [INNER_W-1:0] fade_inner(input logic [Q_BITS-1:0] t2,
                                                      input logic [Q_BITS-1:0] t);
        logic [INNER_EXT-1:0] acc;
        acc = INNER_EXT'(FADE_C6) * INNER_EXT'(t2) + INNER_EXT'(FADE_C10 * ONE_Q16)
            - INNER_EXT'(FADE_C15) * INNER_EXT'(t);
        return acc[INNER_W-1:0];
    endfunction

    function automatic logic signed [GRAD_W-1:0] apply_coef(input coef_t c,
                                                           input logic signed [GRAD_W-1:0] v);
        logic signed [GRAD_W-1:0] r;
        unique case (c)
            COEF_POS:  r = v;
            COEF_NEG:  r = -v;
            COEF_ZERO: r = '0;
            default:   r = '0;
        endcase
        return r;
    endfunction

    function automatic logic signed [GRAD_W-1:0] grad(input logic [3:0] h,
                                                     input logic signed [GRAD_W-1:0] x,
                                                     input logic signed [GRAD_W-1:0] y);
        return apply_coef(GRAD_X_TBL[h], x) + apply_coef(GRAD_Y_TBL[h], y);
    endfunction

    // a + floor(u * d / 2^16)
    function automatic logic signed [VAL_W-1:0] blend(input logic [FADE_W-1:0] u,
                                                     input logic signed [VAL_W-1:0] a,
                                                     input logic signed [VAL_W-1:0] d);
        logic signed [FADE_W+VAL_W:0] p;
        logic signed [FADE_W+VAL_W:0] s;
        p = $signed({1'b0, u}) * d;
        s = p >>> Q_BITS;
        return a + s[VAL_W-1:0];
    endfunction

    // floor(r / 4), clamped to the output range
    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [VAL_W-1:0] r);
        logic signed [VAL_W-1:0] q;
        logic signed [OUT_W-1:0] o;
        q = r >>> OUT_SHIFT;
        priority if (q > VAL_W'(SAT_MAX))
            o = OUT_W'(SAT_MAX);
        else if (q < VAL_W'(SAT_MIN))
            o = OUT_W'(SAT_MIN);
        else
            o = q[OUT_W-1:0];
        return o;
    endfunction

endpackage

`default_nettype wire

@@ rtl/gradient_noise_2d.sv @@
// gradient noise 2d: loadable permutation table and seven-stage evaluation pipeline
// an evaluate transaction passes stages 1 to 6 and then the output register
// throughput: one transaction per cycle unless out_ready stalls; a load takes one slot and yields no result
// the table is held in five copies over the three lookup stages, each with two read ports
// reset: after rst_n rises, a pass over all table indices writes the identity into every copy,
// with in_ready low until it ends
`timescale 1ns / 1ps
`default_nettype none

module gradient_noise_2d (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire logic                                      in_valid,
    output logic                                           in_ready,
    input  wire logic                                      op,
    input  wire logic [gn2d_pkg::IDX_W-1:0]                perm_index,
    input  wire logic [gn2d_pkg::IDX_W-1:0]                perm_value,
    input  wire logic signed [gn2d_pkg::COORD_W-1:0]       x_coord,
    input  wire logic signed [gn2d_pkg::COORD_W-1:0]       y_coord,
    output logic                                           out_valid,
    input  wire logic                                      out_ready,
    output logic signed [gn2d_pkg::OUT_W-1:0]              noise_value
);

    localparam int IW = gn2d_pkg::IDX_W;
    localparam int QW = gn2d_pkg::Q_BITS;
    localparam int NW = gn2d_pkg::INNER_W;
    localparam int UW = gn2d_pkg::FADE_W;
    localparam int GW = gn2d_pkg::GRAD_W;
    localparam int VW = gn2d_pkg::VAL_W;

    // table copies: a for the cell rows, b/c for the corners, d/e for the hashes
    logic [IW-1:0] mem_a [gn2d_pkg::TABLE_SIZE];
    logic [IW-1:0] mem_b [gn2d_pkg::TABLE_SIZE];
    logic [IW-1:0] mem_c [gn2d_pkg::TABLE_SIZE];
    logic [IW-1:0] mem_d [gn2d_pkg::TABLE_SIZE];
    logic [IW-1:0] mem_e [gn2d_pkg::TABLE_SIZE];

    logic [IW:0]   init_cnt_reg;
    logic [IW:0]   init_cnt_next;
    logic          init_done;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, out_valid_reg;
    logic v1_next, v2_next, v3_next, v4_next, v5_next, v6_next, out_valid_next;
    logic en1, en2, en3, en4, en5, en6, en7;
    logic in_fire;

    // stage 1
    logic          s1_op_reg;
    logic [IW-1:0] s1_idx_reg, s1_val_reg, s1_cy_reg, s1_pa_reg, s1_pb_reg;
    logic [QW-1:0] s1_fx_reg, s1_fy_reg, s1_t2x_reg, s1_t2y_reg;
    logic [IW-1:0] s1_cx_next, s1_cy_next;
    logic [QW-1:0] s1_fx_next, s1_fy_next, s1_t2x_next, s1_t2y_next;
    logic [2*QW-1:0] sq_x, sq_y;

    // stage 2
    logic          s2_op_reg;
    logic [IW-1:0] s2_idx_reg, s2_val_reg;
    logic [IW-1:0] s2_aa_reg, s2_ab_reg, s2_ba_reg, s2_bb_reg;
    logic [QW-1:0] s2_fx_reg, s2_fy_reg, s2_t3x_reg, s2_t3y_reg;
    logic [NW-1:0] s2_inx_reg, s2_iny_reg;
    logic [IW-1:0] s2_a0_next, s2_a1_next, s2_b0_next, s2_b1_next;
    logic [2*QW-1:0] cu_x, cu_y;
    logic [QW-1:0] s2_t3x_next, s2_t3y_next;

    // stage 3
    logic [IW-1:0] s3_haa_reg, s3_hab_reg, s3_hba_reg, s3_hbb_reg;
    logic [QW-1:0] s3_fx_reg, s3_fy_reg;
    logic [UW-1:0] s3_u_reg, s3_v_reg;
    logic [QW+NW-1:0] fd_x, fd_y;
    logic [UW-1:0] s3_u_next, s3_v_next;

    // stage 4
    logic signed [GW-1:0] x0, x1, y0, y1, g_aa, g_ab, g_ba, g_bb;
    logic signed [VW-1:0] s4_lo_a_reg, s4_lo_d_reg, s4_hi_a_reg, s4_hi_d_reg;
    logic signed [VW-1:0] s4_lo_a_next, s4_lo_d_next, s4_hi_a_next, s4_hi_d_next;
    logic [UW-1:0] s4_u_reg, s4_v_reg;

    // stages 5, 6 and output
    logic signed [VW-1:0] s5_lo_reg, s5_hi_reg, s5_lo_next, s5_hi_next;
    logic [UW-1:0] s5_v_reg, s6_v_reg;
    logic signed [VW-1:0] s6_lo_reg, s6_d_reg, s6_d_next;
    logic signed [gn2d_pkg::OUT_W-1:0] noise_value_reg, noise_value_next;

    // table write ports
    logic          wr_a_en, wr_bc_en, wr_de_en;
    logic [IW-1:0] wr_a_addr, wr_a_data, wr_bc_addr, wr_bc_data, wr_de_addr, wr_de_data;

    assign init_done = init_cnt_reg[IW];

    // per-stage advance: a stage moves when it is empty or the next one moves
    always_comb
    begin
        en7      = !out_valid_reg || out_ready;
        en6      = !v6_reg || en7;
        en5      = !v5_reg || en6;
        en4      = !v4_reg || en5;
        en3      = !v3_reg || en4;
        en2      = !v2_reg || en3;
        en1      = !v1_reg || en2;
        in_ready = en1 && init_done;
        in_fire  = in_valid && in_ready;
    end

    always_comb
    begin
        init_cnt_next  = init_done ? init_cnt_reg : init_cnt_reg + 1'b1;
        v1_next        = en1 ? in_fire : v1_reg;
        v2_next        = en2 ? v1_reg : v2_reg;
        // loads end at stage 2 once their last table copies are written
        v3_next        = en3 ? (v2_reg && s2_op_reg == gn2d_pkg::OP_EVAL) : v3_reg;
        v4_next        = en4 ? v3_reg : v4_reg;
        v5_next        = en5 ? v4_reg : v5_reg;
        v6_next        = en6 ? v5_reg : v6_reg;
        out_valid_next = en7 ? v6_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_cnt_reg  <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            init_cnt_reg  <= init_cnt_next;
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            v3_reg        <= v3_next;
            v4_reg        <= v4_next;
            v5_reg        <= v5_next;
            v6_reg        <= v6_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // each copy takes a load when the load passes the stage that reads it
    always_comb
    begin
        wr_a_en    = !init_done || (in_fire && op == gn2d_pkg::OP_LOAD);
        wr_a_addr  = init_done ? perm_index : init_cnt_reg[IW-1:0];
        wr_a_data  = init_done ? perm_value : init_cnt_reg[IW-1:0];
        wr_bc_en   = !init_done || (en2 && v1_reg && s1_op_reg == gn2d_pkg::OP_LOAD);
        wr_bc_addr = init_done ? s1_idx_reg : init_cnt_reg[IW-1:0];
        wr_bc_data = init_done ? s1_val_reg : init_cnt_reg[IW-1:0];
        wr_de_en   = !init_done || (en3 && v2_reg && s2_op_reg == gn2d_pkg::OP_LOAD);
        wr_de_addr = init_done ? s2_idx_reg : init_cnt_reg[IW-1:0];
        wr_de_data = init_done ? s2_val_reg : init_cnt_reg[IW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (wr_a_en)
        begin
            mem_a[wr_a_addr] <= wr_a_data;
        end
        if (wr_bc_en)
        begin
            mem_b[wr_bc_addr] <= wr_bc_data;
            mem_c[wr_bc_addr] <= wr_bc_data;
        end
        if (wr_de_en)
        begin
            mem_d[wr_de_addr] <= wr_de_data;
            mem_e[wr_de_addr] <= wr_de_data;
        end
    end

    // stage 1: cell, offsets, t^2, cell row lookups
    always_comb
    begin
        s1_cx_next  = x_coord[gn2d_pkg::FRAC_BITS +: IW];
        s1_cy_next  = y_coord[gn2d_pkg::FRAC_BITS +: IW];
        s1_fx_next  = gn2d_pkg::frac_q16(x_coord);
        s1_fy_next  = gn2d_pkg::frac_q16(y_coord);
        sq_x        = (2*QW)'(s1_fx_next) * (2*QW)'(s1_fx_next);
        sq_y        = (2*QW)'(s1_fy_next) * (2*QW)'(s1_fy_next);
        s1_t2x_next = sq_x[2*QW-1:QW];
        s1_t2y_next = sq_y[2*QW-1:QW];
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_op_reg  <= op;
            s1_idx_reg <= perm_index;
            s1_val_reg <= perm_value;
            s1_cy_reg  <= s1_cy_next;
            s1_fx_reg  <= s1_fx_next;
            s1_fy_reg  <= s1_fy_next;
            s1_t2x_reg <= s1_t2x_next;
            s1_t2y_reg <= s1_t2y_next;
            s1_pa_reg  <= mem_a[s1_cx_next];
            s1_pb_reg  <= mem_a[s1_cx_next + 1'b1];
        end
    end

    // stage 2: corner lookups, t^3 and the fade polynomial's inner term
    always_comb
    begin
        s2_a0_next  = s1_pa_reg + s1_cy_reg;
        s2_a1_next  = s1_pa_reg + s1_cy_reg + 1'b1;
        s2_b0_next  = s1_pb_reg + s1_cy_reg;
        s2_b1_next  = s1_pb_reg + s1_cy_reg + 1'b1;
        cu_x        = (2*QW)'(s1_t2x_reg) * (2*QW)'(s1_fx_reg);
        cu_y        = (2*QW)'(s1_t2y_reg) * (2*QW)'(s1_fy_reg);
        s2_t3x_next = cu_x[2*QW-1:QW];
        s2_t3y_next = cu_y[2*QW-1:QW];
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_op_reg  <= s1_op_reg;
            s2_idx_reg <= s1_idx_reg;
            s2_val_reg <= s1_val_reg;
            s2_fx_reg  <= s1_fx_reg;
            s2_fy_reg  <= s1_fy_reg;
            s2_t3x_reg <= s2_t3x_next;
            s2_t3y_reg <= s2_t3y_next;
            s2_inx_reg <= gn2d_pkg::fade_inner(s1_t2x_reg, s1_fx_reg);
            s2_iny_reg <= gn2d_pkg::fade_inner(s1_t2y_reg, s1_fy_reg);
            s2_aa_reg  <= mem_b[s2_a0_next];
            s2_ab_reg  <= mem_b[s2_a1_next];
            s2_ba_reg  <= mem_c[s2_b0_next];
            s2_bb_reg  <= mem_c[s2_b1_next];
        end
    end

    // stage 3: corner hashes and the faded weights
    always_comb
    begin
        fd_x      = (QW+NW)'(s2_t3x_reg) * (QW+NW)'(s2_inx_reg);
        fd_y      = (QW+NW)'(s2_t3y_reg) * (QW+NW)'(s2_iny_reg);
        s3_u_next = fd_x[QW +: UW];
        s3_v_next = fd_y[QW +: UW];
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            s3_fx_reg  <= s2_fx_reg;
            s3_fy_reg  <= s2_fy_reg;
            s3_u_reg   <= s3_u_next;
            s3_v_reg   <= s3_v_next;
            s3_haa_reg <= mem_d[s2_aa_reg];
            s3_hab_reg <= mem_d[s2_ab_reg];
            s3_hba_reg <= mem_e[s2_ba_reg];
            s3_hbb_reg <= mem_e[s2_bb_reg];
        end
    end

    // stage 4: corner gradients and the x-direction differences
    always_comb
    begin
        x0 = $signed(GW'(s3_fx_reg));
        y0 = $signed(GW'(s3_fy_reg));
        x1 = x0 - GW'(gn2d_pkg::ONE_Q16);
        y1 = y0 - GW'(gn2d_pkg::ONE_Q16);
        g_aa = gn2d_pkg::grad(s3_haa_reg[3:0], x0, y0);
        g_ba = gn2d_pkg::grad(s3_hba_reg[3:0], x1, y0);
        g_ab = gn2d_pkg::grad(s3_hab_reg[3:0], x0, y1);
        g_bb = gn2d_pkg::grad(s3_hbb_reg[3:0], x1, y1);
        s4_lo_a_next = VW'(g_aa);
        s4_lo_d_next = VW'(g_ba) - VW'(g_aa);
        s4_hi_a_next = VW'(g_ab);
        s4_hi_d_next = VW'(g_bb) - VW'(g_ab);
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            s4_lo_a_reg <= s4_lo_a_next;
            s4_lo_d_reg <= s4_lo_d_next;
            s4_hi_a_reg <= s4_hi_a_next;
            s4_hi_d_reg <= s4_hi_d_next;
            s4_u_reg    <= s3_u_reg;
            s4_v_reg    <= s3_v_reg;
        end
    end

    // stage 5: blend along x
    always_comb
    begin
        s5_lo_next = gn2d_pkg::blend(s4_u_reg, s4_lo_a_reg, s4_lo_d_reg);
        s5_hi_next = gn2d_pkg::blend(s4_u_reg, s4_hi_a_reg, s4_hi_d_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            s5_lo_reg <= s5_lo_next;
            s5_hi_reg <= s5_hi_next;
            s5_v_reg  <= s4_v_reg;
        end
    end

    // stage 6: y-direction difference
    assign s6_d_next = s5_hi_reg - s5_lo_reg;

    always_ff @(posedge clk)
    begin
        if (en6)
        begin
            s6_lo_reg <= s5_lo_reg;
            s6_d_reg  <= s6_d_next;
            s6_v_reg  <= s5_v_reg;
        end
    end

    // output stage: blend along y, scale to q2.14 and clamp
    assign noise_value_next = gn2d_pkg::sat_out(gn2d_pkg::blend(s6_v_reg, s6_lo_reg, s6_d_reg));

    always_ff @(posedge clk)
    begin
        if (en7)
        begin
            noise_value_reg <= noise_value_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign noise_value = noise_value_reg;

endmodule

`default_nettype wire

@@ rtl/gn2d_checker.sv @@
// port-level checker for the gradient noise block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "gradient_noise_2d_assert.svh"

module gn2d_checker (
    input wire logic                                  clk,
    input wire logic                                  rst_n,
    input wire logic                                  in_valid,
    input wire logic                                  in_ready,
    input wire logic                                  op,
    input wire logic                                  out_valid,
    input wire logic                                  out_ready,
    input wire logic signed [gn2d_pkg::OUT_W-1:0]     noise_value
);

    localparam int PW = $clog2(gn2d_pkg::PIPE_DEPTH + 1) + 1;

    logic [PW-1:0] pending_reg;
    logic [PW-1:0] pending_next;
    logic          eval_fire;
    logic          out_fire;

    // evaluate transactions accepted and not yet delivered
    always_comb
    begin
        eval_fire    = in_valid && in_ready && op == gn2d_pkg::OP_EVAL;
        out_fire     = out_valid && out_ready;
        pending_next = pending_reg + PW'(eval_fire) - PW'(out_fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    `GN2D_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(noise_value), "result dropped or changed while stalled")
    `GN2D_ASSERT_IMPLIES(a_init_block, !$past(rst_n), !in_ready, "input taken during table initialization")
    `GN2D_ASSERT_IMPLIES(a_no_orphan, out_valid, pending_reg != '0, "result without a pending evaluate transaction")
    `GN2D_ASSERT_IMPLIES(a_depth, in_valid || !in_valid, pending_reg <= PW'(gn2d_pkg::PIPE_DEPTH), "more transactions in flight than pipeline stages")

endmodule

bind gradient_noise_2d gn2d_checker u_gn2d_checker (.*);

`default_nettype wire
